FILE: src/stb_pkg.sv
package stb_pkg;

	localparam int FLAG_W = 10;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_SETUP   = 3'd1;
	localparam logic [2:0] KIND_ENABLE  = 3'd2;
	localparam logic [2:0] KIND_DISABLE = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] delay_ms;
		logic        single_run;
	} req_t;

	typedef struct packed {
		logic [FLAG_W-1:0] fired_mask;
		logic [FLAG_W-1:0] ticked_flags;
		logic [FLAG_W-1:0] enabled_flags;
		logic [31:0]       elapsed_ms;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_WR,
		ST_DONE
	} st_t;

endpackage

FILE: src/software_timer_bank.sv
// channel   valid      stall      payload
// request   req_valid  req_stall  req (stb_pkg::req_t)
// response  rsp_valid  rsp_stall  rsp (stb_pkg::rsp_t)
//
// One request in flight at a time; req_stall is high from acceptance until its
// response is loaded into the output register.
// A tick walks every slot in turn: the counter table has one read and one write port,
// and each slot passes through ST_RD and then ST_WR on the shared decrementer.
// Setup, enable, disable and clear pass through ST_EXEC and then ST_DONE.
// Reset clears all flags, the elapsed count and the sequencer; the tables are not cleared.
// A stalled response holds the sequencer in its final state until rsp_stall falls.
module software_timer_bank #(
	parameter int SLOTS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  stb_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output stb_pkg::rsp_t   rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = (SLOTS > stb_pkg::FLAG_W) ? SLOTS : stb_pkg::FLAG_W;
	localparam logic [5:0] SLOTS_W = 6'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	stb_pkg::st_t state_q, state_d;
	stb_pkg::req_t req_q;

	logic [31:0] count_mem  [SLOTS];
	logic [31:0] reload_mem [SLOTS];
	logic [31:0] cnt_rd_q, rel_rd_q;

	logic [SLOTS-1:0] present_q, enable_q, ticked_q, oneshot_q, fired_q;
	logic [31:0]      elapsed_q;
	logic [IW-1:0]    idx_q;
	logic             rsp_valid_q;
	stb_pkg::rsp_t    rsp_q;

	logic [4:0]    slot_ext;
	logic [IW-1:0] slot_idx;
	logic          slot_ok;
	logic          accept, out_free;
	logic [31:0]   dec;
	logic          active, hit_zero;
	logic          cnt_we, rel_we;
	logic [IW-1:0] waddr;
	logic [31:0]   cnt_wdata;
	logic [PW-1:0] ticked_pad, enable_pad, fired_pad;

	assign slot_ext = {1'b0, req_q.slot};
	assign slot_idx = slot_ext[IW-1:0];
	assign slot_ok  = {1'b0, slot_ext} < SLOTS_W;
	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign dec      = cnt_rd_q - 32'd1;
	assign active   = present_q[idx_q] && enable_q[idx_q];
	assign hit_zero = (dec == 32'd0);

	assign ticked_pad = PW'(ticked_q);
	assign enable_pad = PW'(enable_q);
	assign fired_pad  = PW'(fired_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		cnt_we    = 1'b0;
		rel_we    = 1'b0;
		waddr     = idx_q;
		cnt_wdata = hit_zero ? rel_rd_q : dec;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = (req.kind == stb_pkg::KIND_TICK) ? stb_pkg::ST_RD
						: stb_pkg::ST_EXEC;
				end
			end
			stb_pkg::ST_EXEC: begin
				waddr     = slot_idx;
				cnt_wdata = req_q.delay_ms;
				if (slot_ok && req_q.kind == stb_pkg::KIND_SETUP) begin
					cnt_we = 1'b1;
					rel_we = 1'b1;
				end
				state_d = stb_pkg::ST_DONE;
			end
			stb_pkg::ST_RD: begin
				state_d = stb_pkg::ST_WR;
			end
			stb_pkg::ST_WR: begin
				cnt_we  = active;
				state_d = (idx_q == LAST_IDX) ? stb_pkg::ST_DONE : stb_pkg::ST_RD;
			end
			stb_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = stb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	// table ports
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[waddr] <= cnt_wdata;
		end
		if (rel_we) begin
			reload_mem[waddr] <= req_q.delay_ms;
		end
		cnt_rd_q <= count_mem[idx_q];
		rel_rd_q <= reload_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			enable_q    <= '0;
			ticked_q    <= '0;
			oneshot_q   <= '0;
			fired_q     <= '0;
			elapsed_q   <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == stb_pkg::ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				stb_pkg::ST_IDLE: begin
					if (accept) begin
						fired_q <= '0;
						idx_q   <= '0;
						if (req.kind == stb_pkg::KIND_TICK) begin
							elapsed_q <= elapsed_q + 32'd1;
						end
					end
				end
				stb_pkg::ST_EXEC: begin
					if (slot_ok) begin
						unique case (req_q.kind)
							stb_pkg::KIND_SETUP: begin
								present_q[slot_idx] <= 1'b1;
								enable_q[slot_idx]  <= 1'b0;
								ticked_q[slot_idx]  <= 1'b0;
								oneshot_q[slot_idx] <= req_q.single_run;
							end
							stb_pkg::KIND_ENABLE: begin
								enable_q[slot_idx] <= 1'b1;
								ticked_q[slot_idx] <= 1'b0;
							end
							stb_pkg::KIND_DISABLE: begin
								enable_q[slot_idx] <= 1'b0;
							end
							stb_pkg::KIND_CLEAR: begin
								ticked_q[slot_idx] <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				stb_pkg::ST_RD: begin
				end
				stb_pkg::ST_WR: begin
					if (active && hit_zero) begin
						ticked_q[idx_q] <= 1'b1;
						fired_q[idx_q]  <= 1'b1;
						if (oneshot_q[idx_q]) begin
							enable_q[idx_q] <= 1'b0;
						end
					end
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				stb_pkg::ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == stb_pkg::ST_DONE && out_free) begin
			rsp_q.fired_mask    <= fired_pad[stb_pkg::FLAG_W-1:0];
			rsp_q.ticked_flags  <= ticked_pad[stb_pkg::FLAG_W-1:0];
			rsp_q.enabled_flags <= enable_pad[stb_pkg::FLAG_W-1:0];
			rsp_q.elapsed_ms    <= elapsed_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: tb/tb_software_timer_bank.sv
`timescale 1ns / 100ps

module tb_software_timer_bank;

	localparam int CLK_PERIOD    = 8;
	localparam int SLOTS         = 10;
	localparam int KIND_TOP      = 7;
	localparam int MAX_WAIT      = 9;
	localparam int LONG_HOLD     = 400;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 3 * (2 * SLOTS + 2);
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 200;
	localparam int PRINT_LIMIT   = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	stb_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	stb_pkg::rsp_t rsp;

	stb_pkg::req_t pending_req[$];
	stb_pkg::rsp_t expected_rsp[$];

	// timer bank state as predicted
	logic [31:0]      reload_ms [SLOTS];
	logic [31:0]      remain_ms [SLOTS];
	logic [SLOTS-1:0] present_m = '0;
	logic [SLOTS-1:0] enable_m = '0;
	logic [SLOTS-1:0] ticked_m = '0;
	logic [SLOTS-1:0] oneshot_m = '0;
	logic [31:0]      elapsed = '0;

	stb_pkg::rsp_t predicted;
	int   mismatch_count = 0;
	int   send_wait = 0;
	int   gap_draw;
	int   stall_wait = 0;
	int   hold_draw;
	bit   send_gapless = 1'b0;
	bit   take_gapless = 1'b0;
	int   hold_asked = 0;
	int   hold_taken = 0;
	int   idle_cycles;

	software_timer_bank #(
		.SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic advance_timers(input stb_pkg::req_t r, output stb_pkg::rsp_t o);
		logic [SLOTS-1:0] fired;
		fired = '0;
		if (r.kind == stb_pkg::KIND_TICK) begin
			elapsed = elapsed + 1;
			for (int i = 0; i < SLOTS; i++) begin
				if (present_m[i] && enable_m[i]) begin
					remain_ms[i] = remain_ms[i] - 1;
					if (remain_ms[i] == 0) begin
						remain_ms[i] = reload_ms[i];
						ticked_m[i] = 1'b1;
						fired[i] = 1'b1;
						if (oneshot_m[i])
							enable_m[i] = 1'b0;
					end
				end
			end
		end else if (r.slot < SLOTS) begin
			case (r.kind)
			stb_pkg::KIND_SETUP: begin
				reload_ms[r.slot] = r.delay_ms;
				remain_ms[r.slot] = r.delay_ms;
				present_m[r.slot] = 1'b1;
				enable_m[r.slot] = 1'b0;
				ticked_m[r.slot] = 1'b0;
				oneshot_m[r.slot] = r.single_run;
			end
			stb_pkg::KIND_ENABLE: begin
				enable_m[r.slot] = 1'b1;
				ticked_m[r.slot] = 1'b0;
			end
			stb_pkg::KIND_DISABLE: begin
				enable_m[r.slot] = 1'b0;
			end
			stb_pkg::KIND_CLEAR: begin
				ticked_m[r.slot] = 1'b0;
			end
			default: begin
			end
			endcase
		end
		o.fired_mask = fired;
		o.ticked_flags = ticked_m;
		o.enabled_flags = enable_m;
		o.elapsed_ms = elapsed;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_response(input stb_pkg::rsp_t got);
		stb_pkg::rsp_t want;
		if (expected_rsp.size() == 0) begin
			report_mismatch("unrequested response, elapsed_ms", got.elapsed_ms, '0);
			return;
		end
		want = expected_rsp.pop_front();
		if (got.fired_mask !== want.fired_mask)
			report_mismatch("fired_mask", 32'(got.fired_mask), 32'(want.fired_mask));
		if (got.ticked_flags !== want.ticked_flags)
			report_mismatch("ticked_flags", 32'(got.ticked_flags),
				32'(want.ticked_flags));
		if (got.enabled_flags !== want.enabled_flags)
			report_mismatch("enabled_flags", 32'(got.enabled_flags),
				32'(want.enabled_flags));
		if (got.elapsed_ms !== want.elapsed_ms)
			report_mismatch("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
	endtask

	task automatic queue_request(input logic [2:0] kind, input logic [3:0] slot,
			input logic [31:0] delay, input logic one);
		stb_pkg::req_t r;
		r.kind = kind;
		r.slot = slot;
		r.delay_ms = delay;
		r.single_run = one;
		pending_req.push_back(r);
	endtask

	// mostly ticks and slot traffic on real slots, short delays so slots fire often
	function automatic stb_pkg::req_t random_request();
		stb_pkg::req_t r;
		int   pick;
		int   sel;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 19);
		r.delay_ms = $urandom;
		r.single_run = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) != 0)
			r.slot = 4'($urandom_range(0, SLOTS - 1));
		else
			r.slot = 4'($urandom_range(SLOTS, 4'hF));
		if (pick < 45) begin
			r.kind = stb_pkg::KIND_TICK;
		end else if (pick < 60) begin
			r.kind = stb_pkg::KIND_SETUP;
			if (sel < 14)
				r.delay_ms = $urandom_range(1, 8);
			else if (sel < 16)
				r.delay_ms = '0;
			else if (sel >= 18)
				r.delay_ms = $urandom_range(9, 40);
		end else if (pick < 75) begin
			r.kind = stb_pkg::KIND_ENABLE;
		end else if (pick < 83) begin
			r.kind = stb_pkg::KIND_DISABLE;
		end else if (pick < 92) begin
			r.kind = stb_pkg::KIND_CLEAR;
		end else begin
			r.kind = 3'($urandom_range(stb_pkg::KIND_CLEAR + 1, KIND_TOP));
		end
		return r;
	endfunction

	task automatic wait_until_drained();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				advance_timers(req, predicted);
				expected_rsp.push_back(predicted);
			end
			if (req_valid && req_stall) begin
				// hold the request until taken
			end else if (req_valid) begin
				gap_draw = send_gapless ? 0 : $urandom_range(0, MAX_WAIT);
				if (gap_draw == 0 && pending_req.size() != 0) begin
					req <= pending_req.pop_front();
				end else begin
					req_valid <= 1'b0;
					send_wait <= gap_draw;
				end
			end else if (send_wait != 0) begin
				send_wait <= send_wait - 1;
			end else if (pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_wait <= 0;
			hold_taken <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			if (hold_taken != hold_asked) begin
				hold_taken <= hold_taken + 1;
				stall_wait <= LONG_HOLD;
				rsp_stall <= 1'b1;
			end else if (stall_wait != 0) begin
				stall_wait <= stall_wait - 1;
				rsp_stall <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				hold_draw = take_gapless ? 0 : $urandom_range(0, MAX_WAIT);
				rsp_stall <= (hold_draw != 0);
				stall_wait <= (hold_draw != 0) ? hold_draw - 1 : 0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		stb_pkg::req_t r;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_ENABLE, 3, 0, 1'b0);         // enable before setup
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_SETUP, 0, 1, 1'b0);
		queue_request(stb_pkg::KIND_SETUP, 9, 2, 1'b1);
		queue_request(stb_pkg::KIND_SETUP, 3, 0, 1'b0);          // zero delay wraps
		queue_request(stb_pkg::KIND_SETUP, 5, 32'hFFFF_FFFF, 1'b1);
		queue_request(stb_pkg::KIND_ENABLE, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_ENABLE, 9, 0, 1'b0);
		queue_request(stb_pkg::KIND_ENABLE, 3, 0, 1'b0);
		queue_request(stb_pkg::KIND_ENABLE, 5, 0, 1'b0);
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_CLEAR, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_DISABLE, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		queue_request(stb_pkg::KIND_SETUP, 3, 2, 1'b0);          // re-setup of a live slot
		queue_request(stb_pkg::KIND_SETUP, 4'(SLOTS), 5, 1'b0);
		queue_request(stb_pkg::KIND_ENABLE, 4'hF, 0, 1'b0);
		queue_request(3'(stb_pkg::KIND_CLEAR + 1), 0, 32'hFFFF_FFFF, 1'b1);
		queue_request(3'(KIND_TOP), 9, 0, 1'b0);
		queue_request(stb_pkg::KIND_CLEAR, 9, 0, 1'b0);
		queue_request(stb_pkg::KIND_TICK, 0, 0, 1'b0);
		wait_until_drained();

		for (int p = 0; p < PHASES; p++) begin
			send_gapless = (p % 3 == 1) || (p == PHASES - 1);
			take_gapless = (p % 3 == 2) || (p == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = random_request();
				pending_req.push_back(r);
			end
			if (p == 3) begin
				// receiver backs off while requests keep coming
				send_gapless = 1'b1;
				hold_asked++;
			end
			wait_until_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
src/stb_pkg.sv
src/software_timer_bank.sv
tb/tb_software_timer_bank.sv
